>>> rtl/tpkv_pkg.sv
// Package for the touch point to knob value block.
// Holds widths, event and register codes, and the controller/datapath interface types.
// Depends on nothing.
package tpkv_pkg;

    // Serial divider sizes: numerator bits, denominator bits, counter bits.
    localparam int DIV_NW = 45;
    localparam int DIV_DW = 17;
    localparam int DIV_CW = 6;

    // Wide signed width for the candidate value before clamping.
    localparam int VW = 48;

    // Iteration counts of the two divisions.
    localparam logic [DIV_CW-1:0] ATAN_BITS = 6'd24;
    localparam logic [DIV_CW-1:0] MAP_BITS  = 6'd45;

    typedef enum logic [2:0] {
        FUNC_PRESSED  = 3'd0,
        FUNC_STAY     = 3'd1,
        FUNC_RELEASED = 3'd2,
        FUNC_CLICKED  = 3'd3,
        FUNC_SET      = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        CFG_CENTER_X  = 3'd0,
        CFG_CENTER_Y  = 3'd1,
        CFG_OUTER_RAD = 3'd2,
        CFG_BAND      = 3'd3,
        CFG_START     = 3'd4,
        CFG_SWEEP     = 3'd5,
        CFG_MIN_VALUE = 3'd6,
        CFG_MAX_VALUE = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_LOAD  = 4'd1,
        OP_SQX   = 4'd2,
        OP_SQY   = 4'd3,
        OP_SQD   = 4'd4,
        OP_DIVA  = 4'd5,
        OP_POLY  = 4'd6,
        OP_ANGLE = 4'd7,
        OP_REL   = 4'd8,
        OP_MUL   = 4'd9,
        OP_DIVM  = 4'd10,
        OP_QUOT  = 4'd11,
        OP_SETV  = 4'd12,
        OP_STORE = 4'd13,
        OP_OUT   = 4'd14
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic sweep_zero;
        logic in_dead;
        logic div_done;
        logic changed;
    } dp_status_t;

endpackage

>>> rtl/tpkv_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on tpkv_pkg for its widths.
module tpkv_div
    import tpkv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_NW-1:0] num,
    input  logic [DIV_DW-1:0] den,
    input  logic [DIV_CW-1:0] count,
    output logic              done,
    output logic [DIV_NW-1:0] quo
);

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_NW-1:0] num_reg;
    logic [DIV_NW-1:0] quo_reg;

    logic [DIV_DW:0]   rem_sh;
    logic [DIV_DW:0]   diff;
    logic              ge;

    assign rem_sh = {rem_reg, num_reg[DIV_NW-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign diff   = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= count;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_NW-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_NW-2:0], ge};
            rem_reg <= ge ? diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> rtl/tpkv_datapath.sv
// Datapath: configuration registers, shared multiplier, angle and value mapping.
// Depends on tpkv_pkg and instantiates tpkv_div.
module tpkv_datapath
    import tpkv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic signed [15:0] touch_x,
    input  logic signed [15:0] touch_y,
    input  logic signed [31:0] new_value,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    output logic signed [31:0] knob_value
);

    logic signed [15:0] cx_reg, cy_reg;
    logic        [15:0] orad_reg;
    logic        [7:0]  band_reg;
    logic        [8:0]  start_reg;
    logic        [9:0]  sweep_reg;
    logic signed [31:0] minv_reg, maxv_reg;

    logic signed [15:0] tx_reg, ty_reg;
    logic signed [31:0] nv_reg;
    logic signed [16:0] dx_reg, dy_reg;
    logic        [32:0] sum_reg;
    logic        [31:0] dsq_reg;
    logic        [14:0] p_reg;
    logic        [8:0]  ang_reg;
    logic        [9:0]  rel_reg;
    logic signed [44:0] num_reg;
    logic               neg_reg;
    logic signed [VW-1:0] v_reg;
    logic signed [31:0] cur_reg;
    logic signed [31:0] out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg    <= 16'sd32;
            cy_reg    <= 16'sd32;
            orad_reg  <= 16'd29;
            band_reg  <= 8'd8;
            start_reg <= 9'd320;
            sweep_reg <= 10'd384;
            minv_reg  <= 32'sd0;
            maxv_reg  <= 32'sd100;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_CENTER_X:  cx_reg    <= cfg_data[15:0];
                CFG_CENTER_Y:  cy_reg    <= cfg_data[15:0];
                CFG_OUTER_RAD: orad_reg  <= cfg_data[15:0];
                CFG_BAND:      band_reg  <= cfg_data[7:0];
                CFG_START:     start_reg <= cfg_data[8:0];
                CFG_SWEEP:     sweep_reg <= cfg_data[9:0];
                CFG_MIN_VALUE: minv_reg  <= cfg_data;
                CFG_MAX_VALUE: maxv_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Offsets and magnitudes of the touch point.
    logic signed [16:0] dx_next, dy_next;
    logic        [16:0] ax_w, ay_w;
    logic        [15:0] ax, ay, lo, hi;
    logic               swap;

    assign dx_next = {tx_reg[15], tx_reg} - {cx_reg[15], cx_reg};
    assign dy_next = {ty_reg[15], ty_reg} - {cy_reg[15], cy_reg};
    assign ax_w    = dx_reg[16] ? 17'(-dx_reg) : 17'(dx_reg);
    assign ay_w    = dy_reg[16] ? 17'(-dy_reg) : 17'(dy_reg);
    assign ax      = ax_w[15:0];
    assign ay      = ay_w[15:0];
    assign swap    = ay > ax;
    assign lo      = swap ? ax : ay;
    assign hi      = swap ? ay : ax;

    // Dead zone radius: half the inner radius, at least four.
    logic signed [16:0] inner;
    logic        [14:0] dead;

    assign inner = $signed({1'b0, orad_reg}) - $signed({9'b0, band_reg});
    assign dead  = (inner < 17'sd8) ? 15'd4 : inner[15:1];

    // Divider, shared by the atan ratio and the value mapping.
    logic              div_start;
    logic [DIV_NW-1:0] div_num;
    logic [DIV_DW-1:0] div_den;
    logic [DIV_CW-1:0] div_count;
    logic              div_done;
    logic [DIV_NW-1:0] div_quo;
    logic [44:0]       mag;

    assign mag = num_reg[44] ? 45'(-num_reg) : 45'(num_reg);

    always_comb
    begin
        div_start = 1'b0;
        div_num   = {lo, 8'b0, 21'b0};
        div_den   = {1'b0, hi};
        div_count = ATAN_BITS;
        case (cmd.op)
            OP_DIVA: div_start = 1'b1;
            OP_DIVM:
            begin
                div_start = 1'b1;
                div_num   = mag;
                div_den   = {7'b0, sweep_reg};
                div_count = MAP_BITS;
            end
            default: ;
        endcase
    end

    tpkv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .count (div_count),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Shared 16x16 multiplier for the squares and the atan polynomial.
    logic [8:0]  t;
    logic [15:0] ma, mb;
    logic [31:0] mprod;

    assign t = div_quo[8:0];

    always_comb
    begin
        ma = ax;
        mb = ax;
        case (cmd.op)
            OP_SQY:
            begin
                ma = ay;
                mb = ay;
            end
            OP_SQD:
            begin
                ma = {1'b0, dead};
                mb = {1'b0, dead};
            end
            OP_POLY:
            begin
                ma = {7'b0, t};
                mb = {7'b0, 9'd256 - t};
            end
            default: ;
        endcase
    end

    assign mprod = ma * mb;

    // Octant angle from the ratio and the polynomial term.
    logic [19:0] w22;
    logic [15:0] asum;
    logic [8:0]  a0, a1, ang_next;

    assign w22  = {p_reg, 4'b0} + {1'b0, p_reg, 2'b0} + {2'b0, p_reg, 1'b0};
    assign asum = {1'b0, t, 6'b0} + {4'b0, w22[19:8]};
    assign a0   = {1'b0, asum[15:8]};
    assign a1   = swap ? 9'd128 - a0 : a0;

    always_comb
    begin
        if (!dx_reg[16])
            ang_next = dy_reg[16] ? 9'd0 - a1 : a1;
        else
            ang_next = dy_reg[16] ? 9'd256 + a1 : 9'd256 - a1;
    end

    // Angle relative to the start; the gap snaps to the nearer end.
    logic [8:0] r9;
    logic [9:0] r10, rel_next;

    assign r9  = ang_reg - start_reg;
    assign r10 = {1'b0, r9};

    always_comb
    begin
        rel_next = r10;
        if (r10 > sweep_reg)
            rel_next = ((r10 - sweep_reg) <= (10'd512 - r10)) ? sweep_reg : 10'd0;
    end

    // Mapping product and the final clamp.
    logic signed [32:0] span;
    logic signed [43:0] prod;
    logic signed [44:0] num_next;
    logic signed [44:0] q;
    logic signed [VW-1:0] minw, maxw;
    logic signed [31:0] clampv;

    assign span     = {maxv_reg[31], maxv_reg} - {minv_reg[31], minv_reg};
    assign prod     = $signed({1'b0, rel_reg}) * span;
    assign num_next = {prod[43], prod} + $signed({36'b0, sweep_reg[9:1]});
    assign q        = neg_reg ? 45'(-$signed(div_quo)) : $signed(div_quo);
    assign minw     = VW'(minv_reg);
    assign maxw     = VW'(maxv_reg);

    always_comb
    begin
        if (v_reg < minw)
            clampv = minv_reg;
        else if (v_reg > maxw)
            clampv = maxv_reg;
        else
            clampv = v_reg[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cur_reg <= '0;
        else if (cmd.op == OP_STORE)
            cur_reg <= clampv;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                tx_reg <= touch_x;
                ty_reg <= touch_y;
                nv_reg <= new_value;
            end
            OP_SQX:  sum_reg <= {1'b0, mprod};
            OP_SQY:  sum_reg <= sum_reg + {1'b0, mprod};
            OP_SQD:  dsq_reg <= mprod;
            OP_POLY: p_reg   <= mprod[14:0];
            OP_ANGLE: ang_reg <= ang_next;
            OP_REL:  rel_reg <= rel_next;
            OP_MUL:
            begin
                num_reg <= num_next;
                neg_reg <= num_next[44];
            end
            OP_QUOT: v_reg <= minw + VW'(q);
            OP_SETV: v_reg <= VW'(nv_reg);
            OP_OUT:  out_reg <= cur_reg;
            default: ;
        endcase
        if (cmd.op == OP_LOAD)
        begin
            dx_reg <= {touch_x[15], touch_x} - {cx_reg[15], cx_reg};
            dy_reg <= {touch_y[15], touch_y} - {cy_reg[15], cy_reg};
        end
        else if (cmd.op == OP_SQX)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    assign status.sweep_zero = sweep_reg == 10'd0;
    assign status.in_dead    = sum_reg < {1'b0, dsq_reg};
    assign status.div_done   = div_done;
    assign status.changed    = clampv != cur_reg;
    assign knob_value        = out_reg;

endmodule

>>> rtl/tpkv_ctrl.sv
// Controller: event decode, sequencing of the datapath and the result register flags.
// Depends on tpkv_pkg.
module tpkv_ctrl
    import tpkv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] func,
    input  logic       has_point,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       user_changed,
    output logic       redraw,
    output logic       is_pressed,
    output logic       consumed,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [17:0] {
        S_IDLE   = 18'h00001,
        S_DECIDE = 18'h00002,
        S_SQX    = 18'h00004,
        S_SQY    = 18'h00008,
        S_SQD    = 18'h00010,
        S_DEAD   = 18'h00020,
        S_DIVA   = 18'h00040,
        S_WAITA  = 18'h00080,
        S_POLY   = 18'h00100,
        S_ANGLE  = 18'h00200,
        S_REL    = 18'h00400,
        S_MUL    = 18'h00800,
        S_DIVM   = 18'h01000,
        S_WAITM  = 18'h02000,
        S_QUOT   = 18'h04000,
        S_SETV   = 18'h08000,
        S_STORE  = 18'h10000,
        S_FIN    = 18'h20000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] func_reg;
    logic       hp_reg;
    logic       pressed_reg, pressed_next;
    logic       user_reg, user_next;
    logic       redraw_reg, redraw_next;
    logic       cons_reg, cons_next;
    logic       setv_reg, setv_next;
    logic       ov_reg;
    logic       o_user_reg, o_redraw_reg, o_pressed_reg, o_cons_reg;
    logic       slot_free;

    assign slot_free = !ov_reg || out_ready;
    assign in_ready  = state_reg == S_IDLE;

    always_comb
    begin
        state_next   = state_reg;
        pressed_next = pressed_reg;
        user_next    = user_reg;
        redraw_next  = redraw_reg;
        cons_next    = cons_reg;
        setv_next    = setv_reg;
        cmd.op       = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                user_next   = 1'b0;
                redraw_next = 1'b0;
                cons_next   = 1'b1;
                setv_next   = 1'b0;
                state_next  = S_FIN;
                case (func_t'(func_reg))
                    FUNC_PRESSED:
                    begin
                        pressed_next = 1'b1;
                        redraw_next  = 1'b1;
                        if (hp_reg)
                            state_next = status.sweep_zero ? S_FIN : S_SQX;
                    end
                    FUNC_STAY:
                    begin
                        if (hp_reg && pressed_reg)
                            state_next = status.sweep_zero ? S_FIN : S_SQX;
                    end
                    FUNC_RELEASED:
                    begin
                        pressed_next = 1'b0;
                        redraw_next  = 1'b1;
                    end
                    FUNC_CLICKED:
                    begin
                        pressed_next = 1'b0;
                        redraw_next  = 1'b1;
                        if (hp_reg)
                            state_next = status.sweep_zero ? S_FIN : S_SQX;
                    end
                    FUNC_SET:
                    begin
                        setv_next  = 1'b1;
                        state_next = S_SETV;
                    end
                    default: cons_next = 1'b0;
                endcase
            end
            S_SQX:
            begin
                cmd.op     = OP_SQX;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                cmd.op     = OP_SQY;
                state_next = S_SQD;
            end
            S_SQD:
            begin
                cmd.op     = OP_SQD;
                state_next = S_DEAD;
            end
            S_DEAD:    state_next = status.in_dead ? S_FIN : S_DIVA;
            S_DIVA:
            begin
                cmd.op     = OP_DIVA;
                state_next = S_WAITA;
            end
            S_WAITA:
            begin
                if (status.div_done)
                    state_next = S_POLY;
            end
            S_POLY:
            begin
                cmd.op     = OP_POLY;
                state_next = S_ANGLE;
            end
            S_ANGLE:
            begin
                cmd.op     = OP_ANGLE;
                state_next = S_REL;
            end
            S_REL:
            begin
                cmd.op     = OP_REL;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = S_DIVM;
            end
            S_DIVM:
            begin
                cmd.op     = OP_DIVM;
                state_next = S_WAITM;
            end
            S_WAITM:
            begin
                if (status.div_done)
                    state_next = S_QUOT;
            end
            S_QUOT:
            begin
                cmd.op     = OP_QUOT;
                state_next = S_STORE;
            end
            S_SETV:
            begin
                cmd.op     = OP_SETV;
                state_next = S_STORE;
            end
            S_STORE:
            begin
                cmd.op      = OP_STORE;
                user_next   = status.changed && !setv_reg;
                redraw_next = redraw_reg || status.changed;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pressed_reg <= 1'b0;
            user_reg    <= 1'b0;
            redraw_reg  <= 1'b0;
            cons_reg    <= 1'b0;
            setv_reg    <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pressed_reg <= pressed_next;
            user_reg    <= user_next;
            redraw_reg  <= redraw_next;
            cons_reg    <= cons_next;
            setv_reg    <= setv_next;
            if (state_reg == S_FIN && slot_free)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            func_reg <= func;
            hp_reg   <= has_point;
        end
        if (state_reg == S_FIN && slot_free)
        begin
            o_user_reg    <= user_reg;
            o_redraw_reg  <= redraw_reg;
            o_pressed_reg <= pressed_reg;
            o_cons_reg    <= cons_reg;
        end
    end

    assign out_valid    = ov_reg;
    assign user_changed = o_user_reg;
    assign redraw       = o_redraw_reg;
    assign is_pressed   = o_pressed_reg;
    assign consumed     = o_cons_reg;

endmodule

>>> rtl/touch_point_to_knob_value.sv
// Top level of the touch point to knob value block.
// Depends on tpkv_pkg, tpkv_ctrl and tpkv_datapath.
//
//   channel   handshake               payload
//   input     in_valid / in_ready     func, has_point, touch_x, touch_y, new_value
//   result    out_valid / out_ready   knob_value, user_changed, redraw, is_pressed, consumed
//   config    cfg_write               cfg_index, cfg_data
//
// An event that applies a touch point runs the serial divider twice: a 24-bit quotient for
// the atan ratio, then a 45-bit quotient for the value mapping. A set-value event skips
// the touch steps, a touch point in the dead zone stops at that check, other events go straight to the result.
// One event is in flight at a time; a result still waiting in the output register stalls it.
// The result register holds a finished transaction while the next one is accepted.
// Reset clears the value, the pressed flag and loads the configuration defaults.
module touch_point_to_knob_value
    import tpkv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         func,
    input  logic               has_point,
    input  logic signed [15:0] touch_x,
    input  logic signed [15:0] touch_y,
    input  logic signed [31:0] new_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] knob_value,
    output logic               user_changed,
    output logic               redraw,
    output logic               is_pressed,
    output logic               consumed,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    tpkv_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .has_point    (has_point),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .user_changed (user_changed),
        .redraw       (redraw),
        .is_pressed   (is_pressed),
        .consumed     (consumed),
        .cmd          (cmd),
        .status       (status)
    );

    tpkv_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .touch_x    (touch_x),
        .touch_y    (touch_y),
        .new_value  (new_value),
        .cmd        (cmd),
        .status     (status),
        .knob_value (knob_value)
    );

endmodule

>>> bench/tpkv_checker.sv
// Checker for the touch point to knob value block: watches config writes and both channels.
// Predicts each result from its own copy of the registers and state and compares it.
// Depends on tpkv_pkg.
module tpkv_checker
    import tpkv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [2:0]         func,
    input  logic               has_point,
    input  logic signed [15:0] touch_x,
    input  logic signed [15:0] touch_y,
    input  logic signed [31:0] new_value,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] knob_value,
    input  logic               user_changed,
    input  logic               redraw,
    input  logic               is_pressed,
    input  logic               consumed,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 pending,
    output int                 fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] value;
        logic               user;
        logic               redraw;
        logic               pressed;
        logic               consumed;
    } knob_result_t;

    knob_result_t expected_results[$];

    logic signed [15:0] cx, cy;
    logic [15:0]        outer_r;
    logic [7:0]         band;
    logic [8:0]         start_ang;
    logic [9:0]         sweep_r;
    logic signed [31:0] min_v, max_v;
    logic signed [31:0] knob_state;
    logic               pressed_state;

    assign pending = expected_results.size();

    function automatic longint touch_angle(longint dy, longint dx);
        longint ax, ay, t, a;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax == 0 && ay == 0)
            return 0;
        if (ay <= ax)
        begin
            t = (ay << 8) / ax;
            a = (64 * t + ((22 * t * (256 - t)) >> 8)) >> 8;
        end
        else
        begin
            t = (ax << 8) / ay;
            a = 128 - ((64 * t + ((22 * t * (256 - t)) >> 8)) >> 8);
        end
        if (dx >= 0)
        begin
            if (dy < 0)
                a = (512 - a) & 'h1FF;
        end
        else
            a = (dy >= 0) ? (256 - a) : (256 + a);
        return a & 'h1FF;
    endfunction

    // Clamps and stores; returns 1 when the held value changed.
    function automatic bit store_knob(longint v);
        longint c;
        if (v < longint'(min_v))
            c = min_v;
        else if (v > longint'(max_v))
            c = max_v;
        else
            c = v;
        if (32'(c) == knob_state)
            return 0;
        knob_state = 32'(c);
        return 1;
    endfunction

    function automatic bit apply_touch(logic signed [15:0] px, logic signed [15:0] py);
        longint dx, dy, dead, rel, sw, q;
        dx = longint'(px) - longint'(cx);
        dy = longint'(py) - longint'(cy);
        sw = sweep_r;
        if (sw == 0)
            return 0;
        dead = (longint'(outer_r) - longint'(band)) / 2;
        if (dead < 4)
            dead = 4;
        if (dx * dx + dy * dy < dead * dead)
            return 0;
        rel = (touch_angle(dy, dx) + 512 - longint'(start_ang)) & 'h1FF;
        // Angles in the gap go to whichever end of the sweep is closer.
        if (rel > sw)
            rel = (rel - sw <= 512 - rel) ? sw : 0;
        q = (rel * (longint'(max_v) - longint'(min_v)) + sw / 2) / sw;
        return store_knob(longint'(min_v) + q);
    endfunction

    function automatic knob_result_t predict_event(logic [2:0] f, logic hp,
            logic signed [15:0] px, logic signed [15:0] py, logic signed [31:0] nv);
        knob_result_t r;
        r.user = 0;
        r.redraw = 0;
        r.consumed = 1;
        case (f)
            FUNC_PRESSED:
            begin
                pressed_state = 1;
                r.redraw = 1;
                if (hp)
                    r.user = apply_touch(px, py);
            end
            FUNC_STAY:
            begin
                if (pressed_state && hp)
                    r.user = apply_touch(px, py);
                r.redraw = r.user;
            end
            FUNC_RELEASED:
            begin
                pressed_state = 0;
                r.redraw = 1;
            end
            FUNC_CLICKED:
            begin
                pressed_state = 0;
                if (hp)
                    r.user = apply_touch(px, py);
                r.redraw = 1;
            end
            FUNC_SET:
                r.redraw = store_knob(longint'(nv));
            default:
                r.consumed = 0;
        endcase
        r.value = knob_state;
        r.pressed = pressed_state;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        knob_result_t exp_r;
        if (!rst_n)
        begin
            cx = 32;
            cy = 32;
            outer_r = 29;
            band = 8;
            start_ang = 320;
            sweep_r = 384;
            min_v = 0;
            max_v = 100;
            knob_state = 0;
            pressed_state = 0;
            fail_count = 0;
            expected_results.delete();
        end
        else
        begin
            // Output is checked first: an expectation queued this edge cannot be answered yet.
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result transaction, value %0d", $time, knob_value);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (knob_value !== exp_r.value || user_changed !== exp_r.user ||
                        redraw !== exp_r.redraw || is_pressed !== exp_r.pressed ||
                        consumed !== exp_r.consumed)
                    begin
                        $display("%0t: mismatch expected val=%0d usr=%b rdw=%b prs=%b con=%b",
                                 $time, exp_r.value, exp_r.user, exp_r.redraw,
                                 exp_r.pressed, exp_r.consumed);
                        $display("%0t:          actual   val=%0d usr=%b rdw=%b prs=%b con=%b",
                                 $time, knob_value, user_changed, redraw,
                                 is_pressed, consumed);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(
                    predict_event(func, has_point, touch_x, touch_y, new_value));
            if (cfg_write)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_CENTER_X:  cx = cfg_data[15:0];
                    CFG_CENTER_Y:  cy = cfg_data[15:0];
                    CFG_OUTER_RAD: outer_r = cfg_data[15:0];
                    CFG_BAND:      band = cfg_data[7:0];
                    CFG_START:     start_ang = cfg_data[8:0];
                    CFG_SWEEP:     sweep_r = cfg_data[9:0];
                    CFG_MIN_VALUE: min_v = cfg_data;
                    CFG_MAX_VALUE: max_v = cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> bench/touch_point_to_knob_value_tb.sv
// Top of the testbench for the touch point to knob value block.
// Drives events, configuration phases and output back-pressure; tpkv_checker judges results.
// Depends on tpkv_pkg, tpkv_checker and touch_point_to_knob_value.
module touch_point_to_knob_value_tb;
    import tpkv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         func;
    logic               has_point;
    logic signed [15:0] touch_x;
    logic signed [15:0] touch_y;
    logic signed [31:0] new_value;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] knob_value;
    logic               user_changed;
    logic               redraw;
    logic               is_pressed;
    logic               consumed;
    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    int                 pending;
    int                 fail_count;

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_request;
    int  quiet_cycles;
    logic signed [15:0] cur_cx, cur_cy;

    touch_point_to_knob_value i_dut (.*);

    tpkv_checker i_checker (.*);

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Receiver: random back-pressure plus one long hold-off on request.
    initial
    begin
        out_ready = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready <= 0;
                repeat (400) @(posedge clk);
                hold_request = 0;
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_event(logic [2:0] f, logic hp, logic signed [15:0] px,
                              logic signed [15:0] py, logic signed [31:0] nv);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid  <= 1;
        func      <= f;
        has_point <= hp;
        touch_x   <= px;
        touch_y   <= py;
        new_value <= nv;
        // in_ready only moves at rising edges, so the falling edge shows what the next one sees.
        forever
        begin
            @(negedge clk);
            if (in_ready)
            begin
                @(posedge clk);
                break;
            end
        end
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 0;
        if (idx == CFG_CENTER_X)
            cur_cx = data[15:0];
        if (idx == CFG_CENTER_Y)
            cur_cy = data[15:0];
    endtask

    task automatic drain;
        in_valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic logic signed [15:0] near_coord(logic signed [15:0] c, int reach);
        return c + 16'($urandom_range(0, 2 * reach) - reach);
    endfunction

    task automatic random_events(int count);
        logic [2:0]         f;
        logic               hp;
        logic signed [15:0] px, py;
        logic signed [31:0] nv;
        int                 reach;
        int                 i;
        for (i = 0; i < count; i++)
        begin
            reach = ($urandom_range(0, 3) == 0) ? 400 : 60;
            hp = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 4) == 0)
            begin
                px = 16'($urandom);
                py = 16'($urandom);
            end
            else
            begin
                px = near_coord(cur_cx, reach);
                py = near_coord(cur_cy, reach);
            end
            nv = ($urandom_range(0, 1) == 0) ? $urandom : 32'($urandom_range(0, 300) - 150);
            // Mostly press, drag, release gestures; the rest is arbitrary noise.
            case ($urandom_range(0, 9))
                0, 1:       f = FUNC_PRESSED;
                2, 3, 4, 5: f = FUNC_STAY;
                6:          f = FUNC_RELEASED;
                7:          f = FUNC_CLICKED;
                8:          f = FUNC_SET;
                default:    f = 3'($urandom_range(0, 7));
            endcase
            send_event(f, hp, px, py, nv);
        end
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        func = 0;
        has_point = 0;
        touch_x = 0;
        touch_y = 0;
        new_value = 0;
        cfg_write = 0;
        cfg_index = 0;
        cfg_data = 0;
        send_idle_pct = 8;
        recv_idle_pct = 47;
        hold_request = 0;
        quiet_cycles = 0;
        cur_cx = 32;
        cur_cy = 32;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed events on the reset configuration.
        send_event(FUNC_STAY, 1, 60, 32, 0);
        send_event(FUNC_PRESSED, 0, 0, 0, 0);
        send_event(FUNC_STAY, 1, 32, 32, 0);
        send_event(FUNC_STAY, 1, 33, 34, 0);
        send_event(FUNC_STAY, 1, 60, 32, 0);
        send_event(FUNC_STAY, 1, 32, 60, 0);
        send_event(FUNC_STAY, 1, 4, 32, 0);
        send_event(FUNC_STAY, 1, 32, 4, 0);
        send_event(FUNC_STAY, 1, 10, 60, 0);
        send_event(FUNC_STAY, 1, 60, 60, 0);
        send_event(FUNC_STAY, 0, 60, 32, 0);
        send_event(FUNC_RELEASED, 1, 60, 32, 0);
        send_event(FUNC_CLICKED, 1, -32768, -32768, 0);
        send_event(FUNC_CLICKED, 1, 32767, 32767, 0);
        send_event(FUNC_CLICKED, 0, 0, 0, 0);
        send_event(FUNC_SET, 0, 0, 0, 32'h7FFF_FFFF);
        send_event(FUNC_SET, 0, 0, 0, 32'h8000_0000);
        send_event(FUNC_SET, 0, 0, 0, 50);
        send_event(FUNC_SET, 0, 0, 0, 50);
        send_event(3'd5, 1, 60, 32, 7);
        send_event(3'd6, 0, 0, 0, 0);
        send_event(3'd7, 1, -1, -1, -1);
        send_event(FUNC_PRESSED, 1, 32, 60, 0);
        drain();

        random_events(80);
        drain();

        // Extremes: centre at a corner and at the origin, tiny and huge radii, wide range.
        write_reg(CFG_CENTER_X, 32'hFFFF_8000);
        write_reg(CFG_CENTER_Y, 32'h0000_7FFF);
        write_reg(CFG_OUTER_RAD, 0);
        write_reg(CFG_BAND, 255);
        write_reg(CFG_START, 0);
        write_reg(CFG_SWEEP, 512);
        write_reg(CFG_MIN_VALUE, 32'h8000_0000);
        write_reg(CFG_MAX_VALUE, 32'h7FFF_FFFF);
        random_events(70);
        drain();

        write_reg(CFG_CENTER_X, 0);
        write_reg(CFG_CENTER_Y, 0);
        write_reg(CFG_OUTER_RAD, 65535);
        write_reg(CFG_BAND, 0);
        write_reg(CFG_START, 511);
        write_reg(CFG_SWEEP, 1);
        write_reg(CFG_MIN_VALUE, 32'hFFFF_FF00);
        write_reg(CFG_MAX_VALUE, 1000);
        random_events(50);
        drain();

        // Touch disabled, then inverted range with a sweep past a full turn.
        write_reg(CFG_OUTER_RAD, 40);
        write_reg(CFG_BAND, 20);
        write_reg(CFG_SWEEP, 0);
        random_events(30);
        drain();
        write_reg(CFG_SWEEP, 1023);
        write_reg(CFG_MIN_VALUE, 500);
        write_reg(CFG_MAX_VALUE, -500);
        random_events(50);
        drain();

        send_idle_pct = 47;
        recv_idle_pct = 8;
        write_reg(CFG_CENTER_X, 100);
        write_reg(CFG_CENTER_Y, -200);
        write_reg(CFG_OUTER_RAD, 50);
        write_reg(CFG_BAND, 10);
        write_reg(CFG_START, 200);
        write_reg(CFG_SWEEP, 300);
        write_reg(CFG_MIN_VALUE, -1000);
        write_reg(CFG_MAX_VALUE, 3000000);
        random_events(130);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_START, 100);
        write_reg(CFG_SWEEP, 450);
        write_reg(CFG_MIN_VALUE, 10);
        write_reg(CFG_MAX_VALUE, 20);
        hold_request = 1;
        random_events(130);
        drain();

        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
